// ===== sv/skm_pkg.sv =====
// Shared constants and types of the skid-steer mixer.
package skm_pkg;

  localparam int Q_BITS     = 14;
  localparam int Q_ONE      = 1 << Q_BITS;
  localparam int HALF_Q     = Q_ONE / 2;
  localparam int STEER_FULL = 4500;
  localparam int THR_FULL   = 100;
  localparam int MIX_HALF   = 128;
  localparam int MIX_FULL   = 256;
  localparam int DRIVE_FULL = 10000;

  // Both scalings round half up, folded into an exact multiply by a reciprocal.
  localparam int STEER_DIV  = STEER_FULL / 4;
  localparam int STEER_BIAS = STEER_FULL / 8;
  localparam int THR_DIV    = THR_FULL / 4;
  localparam int THR_BIAS   = THR_FULL / 8;

  localparam int SS_SHIFT = 36;
  localparam longint SS_RECIP = ((longint'(1) << SS_SHIFT) + STEER_DIV - 1) / STEER_DIV;
  localparam int TS_SHIFT = 24;
  localparam longint TS_RECIP = ((longint'(1) << TS_SHIFT) + THR_DIV - 1) / THR_DIV;

  localparam int DIV_STEPS = Q_BITS;
  localparam int FIFO_DEPTH = 2;

  typedef struct packed {
    logic        neg;
    logic        over;
    logic [14:0] ss;
    logic [14:0] ts;
    logic [15:0] sat;
  } skm_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } skm_fifo_stat_t;

endpackage

// ===== sv/skm_front.sv =====
// Front end: saturates a command word and scales it to Q1.14 fractions.
module skm_front
  import skm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [13:0]      steer_demand,
  input  logic [6:0]       throttle_pct,
  output logic             push,
  output skm_word_t        push_word
);

  logic        f1_valid_r, f2_valid_r, f3_valid_r;
  logic        f1_neg_r, f2_neg_r;
  logic [12:0] f1_smag_r;
  logic [6:0]  f1_thr_r;
  logic [14:0] f2_ss_r, f2_ts_r;
  skm_word_t   f3_word_r;

  logic [13:0] smag_raw;
  logic [12:0] smag_nxt;
  logic [6:0]  thr_nxt;
  logic [24:0] ns;
  logic [50:0] ps;
  logic [18:0] nt;
  logic [38:0] pt;
  logic [14:0] ss_nxt, ts_nxt;
  skm_word_t   word_nxt;

  always_comb begin
    smag_raw = steer_demand[13] ? 14'(14'd0 - steer_demand) : steer_demand;
    smag_nxt = (smag_raw > 14'(STEER_FULL)) ? 13'(STEER_FULL) : smag_raw[12:0];
    thr_nxt  = (throttle_pct > 7'(THR_FULL)) ? 7'(THR_FULL) : throttle_pct;

    ns = 25'({f1_smag_r, 12'b0}) + 25'(STEER_BIAS);
    ps = 51'(ns) * 51'(SS_RECIP);
    ss_nxt = 15'(ps >> SS_SHIFT);
    nt = 19'({f1_thr_r, 12'b0}) + 19'(THR_BIAS);
    pt = 39'(nt) * 39'(TS_RECIP);
    ts_nxt = 15'(pt >> TS_SHIFT);

    word_nxt.neg  = f2_neg_r;
    word_nxt.ss   = f2_ss_r;
    word_nxt.ts   = f2_ts_r;
    word_nxt.sat  = 16'(f2_ss_r) + 16'(f2_ts_r);
    word_nxt.over = word_nxt.sat > 16'(Q_ONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
      f3_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= accept;
      f2_valid_r <= f1_valid_r;
      f3_valid_r <= f2_valid_r;
    end
    f1_neg_r  <= steer_demand[13];
    f1_smag_r <= smag_nxt;
    f1_thr_r  <= thr_nxt;
    f2_neg_r  <= f1_neg_r;
    f2_ss_r   <= ss_nxt;
    f2_ts_r   <= ts_nxt;
    f3_word_r <= word_nxt;
  end

  assign push      = f3_valid_r;
  assign push_word = f3_word_r;

endmodule

// ===== sv/skm_fifo.sv =====
// Short queue between the front end and the back end.
module skm_fifo
  import skm_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  skm_word_t      wdata,
  input  logic           pop,
  output skm_word_t      rdata,
  output skm_fifo_stat_t stat
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  skm_word_t        mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  always_comb begin
    do_pop    = pop && (count_r != '0);
    do_push   = push && (count_r != CNT_W'(FIFO_DEPTH));
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

// ===== sv/skm_back.sv =====
// Back end: pipelined fair-scale divider, priority mix and drive scaling.
module skm_back
  import skm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [8:0]       mix,
  input  logic             take,
  input  skm_word_t        word,
  output logic             out_valid,
  output logic [14:0]      left_drive,
  output logic [14:0]      right_drive
);

  typedef struct packed {
    skm_word_t   w;
    logic [15:0] rem;
    logic [13:0] nlow;
    logic [13:0] q;
  } div_t;

  typedef struct packed {
    skm_word_t   w;
    logic        sel;
    logic [13:0] fair;
    logic [22:0] prod;
  } m1_t;

  typedef struct packed {
    skm_word_t   w;
    logic        sel;
    logic [14:0] f;
  } m2_t;

  typedef struct packed {
    skm_word_t   w;
    logic        sel;
    logic [29:0] prod;
  } m3_t;

  typedef struct packed {
    logic        lneg;
    logic        rneg;
    logic [28:0] lprod;
    logic [28:0] rprod;
  } m5_t;

  function automatic div_t div_init(skm_word_t w);
    div_t        d;
    logic [28:0] num;
    num    = 29'(longint'(1) << (2 * Q_BITS)) + 29'(w.sat >> 1);
    d.w    = w;
    d.rem  = 16'(num[28:14]);
    d.nlow = num[13:0];
    d.q    = '0;
    return d;
  endfunction

  // One restoring step: one quotient bit of round(Q_ONE * Q_ONE / sat).
  function automatic div_t div_step(div_t s);
    div_t        d;
    logic [16:0] trial;
    d      = s;
    trial  = {s.rem, s.nlow[13]};
    d.nlow = {s.nlow[12:0], 1'b0};
    if (trial >= {1'b0, s.w.sat}) begin
      d.rem = 16'(trial - {1'b0, s.w.sat});
      d.q   = {s.q[12:0], 1'b1};
    end else begin
      d.rem = trial[15:0];
      d.q   = {s.q[12:0], 1'b0};
    end
    return d;
  endfunction

  div_t                 div_r   [DIV_STEPS];
  div_t                 div_nxt [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_r;
  logic [5:0]           mv_r;

  m1_t                m1_r, m1_nxt;
  m2_t                m2_r, m2_nxt;
  m3_t                m3_r, m3_nxt;
  logic signed [16:0] left_r, right_r, left_nxt, right_nxt;
  m5_t                m5_r, m5_nxt;
  logic [14:0]        lout_r, rout_r, lout_nxt, rout_nxt;

  logic [8:0]         m_cl;
  logic [7:0]         dlt;
  logic [14:0]        diff;
  logic [23:0]        fsum;
  logic [14:0]        v;
  logic [16:0]        sc;
  logic [14:0]        scl, s, t;
  logic signed [16:0] sv;
  logic [14:0]        lmag, rmag;
  logic [13:0]        lr, rr;

  always_comb begin
    div_nxt[0] = div_step(div_init(word));
    for (int i = 1; i < DIV_STEPS; i++) begin
      div_nxt[i] = div_step(div_r[i-1]);
    end
  end

  always_comb begin
    m_cl = (mix > 9'(MIX_FULL)) ? 9'(MIX_FULL) : mix;
    m1_nxt.w    = div_r[DIV_STEPS-1].w;
    m1_nxt.fair = div_r[DIV_STEPS-1].q;
    m1_nxt.sel  = (m_cl >= 9'(MIX_HALF));
    dlt = m1_nxt.sel ? 8'(m_cl - 9'(MIX_HALF)) : 8'(9'(MIX_HALF) - m_cl);
    diff = 15'(15'(Q_ONE) - 15'(m1_nxt.fair));
    m1_nxt.prod = 23'(diff) * 23'(dlt);

    fsum = 24'(m1_r.prod) + 24'(MIX_HALF / 2);
    m2_nxt.w   = m1_r.w;
    m2_nxt.sel = m1_r.sel;
    m2_nxt.f   = 15'(m1_r.fair) + 15'(fsum >> $clog2(MIX_HALF));

    v = m2_r.sel ? m2_r.w.ss : m2_r.w.ts;
    m3_nxt.w    = m2_r.w;
    m3_nxt.sel  = m2_r.sel;
    m3_nxt.prod = 30'(v) * 30'(m2_r.f);

    sc  = 17'((m3_r.prod + 30'(HALF_Q)) >> Q_BITS);
    scl = (sc > 17'(Q_ONE)) ? 15'(Q_ONE) : 15'(sc);
    if (!m3_r.w.over) begin
      s = m3_r.w.ss;
      t = m3_r.w.ts;
    end else if (m3_r.sel) begin
      s = scl;
      t = 15'(Q_ONE) - scl;
    end else begin
      t = scl;
      s = 15'(Q_ONE) - scl;
    end
    sv = m3_r.w.neg ? -$signed({2'b00, s}) : $signed({2'b00, s});
    left_nxt  = $signed({2'b00, t}) + sv;
    right_nxt = $signed({2'b00, t}) - sv;

    lmag = left_r[16] ? 15'(-left_r) : 15'(left_r);
    rmag = right_r[16] ? 15'(-right_r) : 15'(right_r);
    m5_nxt.lneg  = left_r[16];
    m5_nxt.rneg  = right_r[16];
    m5_nxt.lprod = 29'(lmag) * 29'(DRIVE_FULL);
    m5_nxt.rprod = 29'(rmag) * 29'(DRIVE_FULL);

    lr = 14'((m5_r.lprod + 29'(HALF_Q)) >> Q_BITS);
    rr = 14'((m5_r.rprod + 29'(HALF_Q)) >> Q_BITS);
    lout_nxt = m5_r.lneg ? 15'(15'd0 - {1'b0, lr}) : {1'b0, lr};
    rout_nxt = m5_r.rneg ? 15'(15'd0 - {1'b0, rr}) : {1'b0, rr};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
      mv_r <= '0;
    end else begin
      dv_r <= {dv_r[DIV_STEPS-2:0], take};
      mv_r <= {mv_r[4:0], dv_r[DIV_STEPS-1]};
    end
    for (int i = 0; i < DIV_STEPS; i++) begin
      div_r[i] <= div_nxt[i];
    end
    m1_r    <= m1_nxt;
    m2_r    <= m2_nxt;
    m3_r    <= m3_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    m5_r    <= m5_nxt;
    lout_r  <= lout_nxt;
    rout_r  <= rout_nxt;
  end

  assign out_valid   = mv_r[5];
  assign left_drive  = lout_r;
  assign right_drive = rout_r;

endmodule

// ===== sv/skid_steer_mixer_top.sv =====
// Top level of the skid-steer mixer: configuration port, front end, queue, back end.
//
// The mixer takes one command word per clock while busy is low and returns each
// result strobed by out_valid for a single cycle. Results cannot be held off, so
// the receiver must capture every strobed word. The rate of one word per clock
// comes from the fully pipelined back end: the fair-scale divider spends one
// stage on each of its 14 quotient bits. Busy rises only when the internal queue
// is full. The priority mix register should be written only while no command is
// in flight.
module skid_steer_mixer_top
  import skm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [13:0] in_steer_demand,
  input  logic [6:0]  in_throttle_pct,
  output logic        out_valid,
  output logic [14:0] out_left_drive,
  output logic [14:0] out_right_drive,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_MIX = 1'b0;
  localparam int   LATENCY = 24;

  logic           [8:0] mix_r;
  logic           accept;
  logic           fifo_push;
  skm_word_t      fifo_wdata, fifo_rdata;
  skm_fifo_stat_t fifo_stat;
  logic           fifo_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r <= 9'(MIX_HALF);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MIX)) begin
      mix_r <= pwdata[8:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MIX) ? {23'b0, mix_r} : '0;

  assign busy     = fifo_stat.full;
  assign accept   = start && !busy;
  assign fifo_pop = !fifo_stat.empty;

  skm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .steer_demand (in_steer_demand),
    .throttle_pct (in_throttle_pct),
    .push         (fifo_push),
    .push_word    (fifo_wdata)
  );

  skm_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fifo_push),
    .wdata (fifo_wdata),
    .pop   (fifo_pop),
    .rdata (fifo_rdata),
    .stat  (fifo_stat)
  );

  skm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .mix         (mix_r),
    .take        (fifo_pop),
    .word        (fifo_rdata),
    .out_valid   (out_valid),
    .left_drive  (out_left_drive),
    .right_drive (out_right_drive)
  );

`ifndef SYNTHESIS
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> (!fifo_stat.full || fifo_pop))
    else $error("Queue written while full.");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("Accepted word produced no result at the expected cycle.");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("Result strobed without a matching accepted word.");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the skid-steer mixer: directed and random commands, mix changes.
`timescale 1ns / 1ps

module testbench;
  import skm_pkg::*;

  localparam int LATENCY        = 24;
  localparam int SETTLE_CYCLES  = LATENCY + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 123;
  localparam logic [2:0] MIX_ADDR = 3'd0;

  typedef struct packed {
    logic [13:0] steer;
    logic [6:0]  thr;
  } mix_cmd_t;

  typedef struct packed {
    logic [14:0] left;
    logic [14:0] right;
  } drive_pair_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [13:0] in_steer_demand = '0;
  logic [6:0]  in_throttle_pct = '0;
  logic        out_valid;
  logic [14:0] out_left_drive;
  logic [14:0] out_right_drive;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mix_cmd_t    cmd_q[$];
  drive_pair_t drive_q[$];
  logic [8:0]  mix_cfg = 9'd128;
  int          idle_pct = 0;
  int          err_count = 0;
  int          quiet_cycles = 0;

  skid_steer_mixer_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_steer_demand (in_steer_demand),
    .in_throttle_pct (in_throttle_pct),
    .out_valid       (out_valid),
    .out_left_drive  (out_left_drive),
    .out_right_drive (out_right_drive),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
    return (n + d / 2) / d;
  endfunction

  function automatic logic [14:0] to_hundredths(longint v);
    longint unsigned mag;
    longint unsigned r;
    longint unsigned res;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    r = round_div(mag * DRIVE_FULL, Q_ONE);
    res = (v < 0) ? (64'd0 - r) : r;
    return res[14:0];
  endfunction

  function automatic drive_pair_t mix_drives(logic [13:0] steer, logic [6:0] thr_raw,
                                             logic [8:0] mix);
    drive_pair_t     d;
    logic            neg;
    longint unsigned smag, thr, ss, ts, sat, fair, f, m;
    longint          sv;
    neg  = steer[13];
    smag = neg ? (longint'(16384) - longint'(steer)) : longint'(steer);
    thr  = longint'(thr_raw);
    if (smag > STEER_FULL) smag = STEER_FULL;
    if (thr > THR_FULL) thr = THR_FULL;
    ss = round_div(smag * Q_ONE, STEER_FULL);
    ts = round_div(thr * Q_ONE, THR_FULL);
    if (ss + ts > Q_ONE) begin
      sat  = ss + ts;
      fair = round_div(longint'(Q_ONE) * Q_ONE, sat);
      m    = (mix > MIX_FULL) ? MIX_FULL : longint'(mix);
      if (m >= MIX_HALF) begin
        f  = fair + round_div((Q_ONE - fair) * (m - MIX_HALF), MIX_HALF);
        ss = round_div(ss * f, Q_ONE);
        if (ss > Q_ONE) ss = Q_ONE;
        ts = Q_ONE - ss;
      end else begin
        f  = fair + round_div((Q_ONE - fair) * (MIX_HALF - m), MIX_HALF);
        ts = round_div(ts * f, Q_ONE);
        if (ts > Q_ONE) ts = Q_ONE;
        ss = Q_ONE - ts;
      end
    end
    sv = neg ? -longint'(ss) : longint'(ss);
    d.left  = to_hundredths(longint'(ts) + sv);
    d.right = to_hundredths(longint'(ts) - sv);
    return d;
  endfunction

  always @(posedge clk) begin : drive_proc
    mix_cmd_t cmd;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        drive_q.push_back(mix_drives(in_steer_demand, in_throttle_pct, mix_cfg));
      end
      if (!start || !busy) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cmd = cmd_q.pop_front();
          start <= 1'b1;
          in_steer_demand <= cmd.steer;
          in_throttle_pct <= cmd.thr;
        end else begin
          start <= 1'b0;
          in_steer_demand <= 14'($urandom);
          in_throttle_pct <= 7'($urandom);
        end
      end
    end
  end

  always @(posedge clk) begin : check_proc
    drive_pair_t want;
    if (rst_n && out_valid) begin
      if (drive_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected word, left %0d right %0d", $time,
                 $signed(out_left_drive), $signed(out_right_drive));
      end else begin
        want = drive_q.pop_front();
        if (out_left_drive !== want.left) begin
          err_count++;
          $display("%0t: left_drive expected %0d actual %0d", $time,
                   $signed(want.left), $signed(out_left_drive));
        end
        if (out_right_drive !== want.right) begin
          err_count++;
          $display("%0t: right_drive expected %0d actual %0d", $time,
                   $signed(want.right), $signed(out_right_drive));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_mix(input logic [8:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MIX_ADDR;
    pwdata <= {23'($urandom_range(32'h007F_FFFF)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    mix_cfg <= value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || start) @(posedge clk);
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [8:0]  phase_mix[NUM_PHASES];
    int          idle_set[3];
    logic [13:0] steer_edges[7];
    logic [6:0]  thr_edges[4];
    mix_cmd_t    cmd;

    phase_mix = '{9'd128, 9'd0, 9'd256, 9'd511, 9'd127, 9'd129, 9'd257, 9'd64,
                  9'd0, 9'd0};
    phase_mix[8] = 9'($urandom_range(256));
    phase_mix[9] = 9'($urandom_range(511));
    idle_set = '{0, 85, 23};
    steer_edges = '{-14'sd4500, 14'sd4500, 14'd0, -14'sd4501, 14'sd4501, 14'h2000, 14'h1FFF};
    thr_edges = '{7'd0, 7'd100, 7'd101, 7'd127};

    // Full-lock and saturation corners first, at the reset mix.
    cmd_q = '{
      '{14'd0, 7'd0},       '{14'sd4500, 7'd0},   '{-14'sd4500, 7'd0},
      '{14'd0, 7'd100},     '{14'sd4500, 7'd100}, '{-14'sd4500, 7'd100},
      '{14'h1FFF, 7'd127},  '{14'h2000, 7'd127},  '{14'sd4501, 7'd101},
      '{-14'sd4501, 7'd50}, '{14'sd2250, 7'd50},  '{-14'sd2250, 7'd50},
      '{14'd1, 7'd1},       '{-14'sd1, 7'd99},    '{14'sd4500, 7'd50},
      '{14'd0, 7'd127},     '{14'h2000, 7'd0},    '{14'h1FFF, 7'd100},
      '{14'sd3000, 7'd80},  '{-14'sd3000, 7'd80}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        wait_idle();
        write_mix(phase_mix[p]);
      end
      idle_pct = idle_set[p % 3];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(7))
          0: begin
            cmd.steer = 14'($urandom);
            cmd.thr   = 7'($urandom);
          end
          1: begin
            cmd.steer = steer_edges[$urandom_range(6)];
            cmd.thr   = thr_edges[$urandom_range(3)];
          end
          default: begin
            cmd.steer = 14'($urandom_range(9000)) - 14'd4500;
            cmd.thr   = 7'($urandom_range(100));
          end
        endcase
        cmd_q.push_back(cmd);
      end
    end

    wait_idle();
    if (err_count == 0 && drive_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (drive_q.size() != 0) begin
        $display("%0t: %0d expected words never arrived", $time, drive_q.size());
      end
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
